// ===== rtl/scg_pkg.sv =====
`timescale 1ns / 1ps
package scg_pkg;

  localparam int DEG_W       = 6;
  localparam int POLY_W      = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [DEG_W-1:0] deg_t;

  localparam deg_t COUNT_MAX   = deg_t'(63);
  localparam deg_t DEG_MIN     = deg_t'(1);
  localparam deg_t DEG_RESET   = deg_t'(3);
  localparam logic [POLY_W-1:0] POLY_RESET = POLY_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_CRC_DEGREE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_LOW   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_BIT   = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_FINAL = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  msg_bit;
    deg_t  deg;
  } entry_t;

endpackage

// ===== rtl/scg_front.sv =====
`timescale 1ns / 1ps
module scg_front #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        msg_bit_i,
  input  logic                        msg_last_i,
  input  scg_pkg::deg_t               crc_degree_i,
  input  logic [scg_pkg::POLY_W-1:0]  poly_low_i,
  output scg_pkg::entry_t             entry_o,
  output logic [MAX_DEGREE-1:0]       rem_o
);

  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  logic [MAX_DEGREE-1:0] rem_q, rem_d;
  scg_pkg::deg_t         count_q, count_d;
  scg_pkg::deg_t         deg_eff;
  scg_pkg::deg_t         count_inc;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] poly_ext;
  logic [MAX_DEGREE-1:0] rem_m;
  logic [MAX_DEGREE-1:0] rem_next;
  logic [IW-1:0]         top_idx;
  logic                  feedback;
  logic                  short_msg;

  always_comb begin
    if (crc_degree_i == '0) begin
      deg_eff = scg_pkg::DEG_MIN;
    end else if (crc_degree_i > scg_pkg::deg_t'(MAX_DEGREE)) begin
      deg_eff = scg_pkg::deg_t'(MAX_DEGREE);
    end else begin
      deg_eff = crc_degree_i;
    end
  end

  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_bits
    assign mask[i] = (deg_eff > scg_pkg::deg_t'(i));
    if (i < scg_pkg::POLY_W) begin : g_poly
      assign poly_ext[i] = poly_low_i[i];
    end else begin : g_zero
      assign poly_ext[i] = 1'b0;
    end
  end

  assign rem_m     = rem_q & mask;
  assign top_idx   = IW'(deg_eff - scg_pkg::DEG_MIN);
  assign feedback  = rem_m[top_idx] ^ msg_bit_i;
  assign rem_next  = ((rem_m << 1) & mask) ^ (feedback ? (poly_ext & mask) : '0);
  assign count_inc = (count_q == scg_pkg::COUNT_MAX) ? count_q : count_q + scg_pkg::DEG_MIN;
  assign short_msg = ({1'b0, count_inc} <= ({1'b0, deg_eff} + 7'd1));

  always_comb begin
    entry_o.msg_bit = msg_bit_i;
    entry_o.deg     = deg_eff;
    rem_o           = rem_next;
    if (!msg_last_i) begin
      entry_o.kind = scg_pkg::KIND_BIT;
    end else if (short_msg) begin
      entry_o.kind = scg_pkg::KIND_SHORT;
    end else begin
      entry_o.kind = scg_pkg::KIND_FINAL;
    end
  end

  always_comb begin
    rem_d   = rem_q;
    count_d = count_q;
    if (accept_i) begin
      if (msg_last_i) begin
        rem_d   = '0;
        count_d = '0;
      end else begin
        rem_d   = rem_next;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      count_q <= '0;
    end else begin
      rem_q   <= rem_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/scg_queue.sv =====
`timescale 1ns / 1ps
module scg_queue #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  scg_pkg::entry_t       wr_entry_i,
  input  logic [MAX_DEGREE-1:0] wr_rem_i,
  output logic                  full_o,
  input  logic                  rd_en_i,
  output scg_pkg::entry_t       rd_entry_o,
  output logic [MAX_DEGREE-1:0] rd_rem_o,
  output logic                  valid_o
);

  localparam int DEPTH = scg_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  scg_pkg::entry_t       entry_q [DEPTH];
  logic [MAX_DEGREE-1:0] rem_q   [DEPTH];
  logic [PW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]         fill_q, fill_d;

  assign full_o     = (fill_q == CW'(DEPTH));
  assign valid_o    = (fill_q != '0);
  assign rd_entry_o = entry_q[rd_ptr_q];
  assign rd_rem_o   = rem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      fill_d = fill_q + CW'(1);
    end else if (rd_en_i && !wr_en_i) begin
      fill_d = fill_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_entry_i;
      rem_q[wr_ptr_q]   <= wr_rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// ===== rtl/scg_back.sv =====
`timescale 1ns / 1ps
module scg_back #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  scg_pkg::entry_t       q_entry_i,
  input  logic [MAX_DEGREE-1:0] q_rem_i,
  output logic                  q_rd_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic                  code_bit_o,
  output logic                  run_last_o,
  output logic                  too_short_o
);

  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  logic                  busy_q, busy_d;
  logic                  head_q, head_d;
  scg_pkg::deg_t         pos_q, pos_d;
  scg_pkg::entry_t       cmd_q, cmd_d;
  logic [MAX_DEGREE-1:0] rem_q, rem_d;
  logic [IW-1:0]         pos_idx;
  logic                  on_last_crc;
  logic                  done;
  logic                  take;
  logic                  load;

  assign pos_idx     = IW'(pos_q - scg_pkg::DEG_MIN);
  assign on_last_crc = !head_q && (pos_q == scg_pkg::DEG_MIN);
  assign done        = (cmd_q.kind != scg_pkg::KIND_FINAL) || on_last_crc;
  assign take        = busy_q && pop_i;
  assign load        = q_valid_i && (!busy_q || (take && done));
  assign q_rd_o      = load;
  assign empty_o     = !busy_q;

  always_comb begin
    code_bit_o  = 1'b0;
    run_last_o  = 1'b0;
    too_short_o = 1'b0;
    case (cmd_q.kind)
      scg_pkg::KIND_BIT: begin
        code_bit_o = cmd_q.msg_bit;
      end
      scg_pkg::KIND_SHORT: begin
        run_last_o  = 1'b1;
        too_short_o = 1'b1;
      end
      scg_pkg::KIND_FINAL: begin
        code_bit_o = head_q ? cmd_q.msg_bit : rem_q[pos_idx];
        run_last_o = on_last_crc;
      end
      default: begin
        code_bit_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    head_d = head_q;
    pos_d  = pos_q;
    cmd_d  = cmd_q;
    rem_d  = rem_q;
    if (load) begin
      busy_d = 1'b1;
      head_d = 1'b1;
      pos_d  = q_entry_i.deg;
      cmd_d  = q_entry_i;
      rem_d  = q_rem_i;
    end else if (take) begin
      if (done) begin
        busy_d = 1'b0;
      end else if (head_q) begin
        head_d = 1'b0;
      end else begin
        pos_d = pos_q - scg_pkg::DEG_MIN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      head_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      head_q <= head_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// ===== rtl/serial_crc_codeword_generator.sv =====
`timescale 1ns / 1ps
// Serial CRC codeword generator, MSB-first polynomial division.
// Input queue side: present msg_bit_i/msg_last_i and raise push; the bit is
// taken on a clock edge where push is high and full is low.
// Result queue side: while empty is low the oldest result sits on
// code_bit_o/run_last_o/too_short_o; pop on an edge retires it.
// Every message bit comes out as one result; the final bit is followed by
// crc_degree remainder bits, MSB first, the last one flagged by run_last_o.
// A message of at most degree+1 bits yields one result with too_short_o set.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 = degree,
// 1 = polynomial low bits) and cfg_data_i; ready is always high.
// An accepted request is written into the queue and then loaded into the
// output register, from which it reaches the result ports and can be popped.
// Throughput: one bit per cycle while full is low; the remainder register
// shifts and XORs on each accepted bit. A final bit occupies the output for
// degree+1 results, during which the two-entry queue absorbs further bits.
// Reset clears the remainder, bit count, queue and output; degree returns
// to 3 and the polynomial to x^3 + x + 1.
// When the receiver stalls, the current result holds and full rises once
// both queue entries are taken.
module serial_crc_codeword_generator #(
  parameter int MAX_DEGREE = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            msg_bit_i,
  input  logic                            msg_last_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            code_bit_o,
  output logic                            run_last_o,
  output logic                            too_short_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [scg_pkg::POLY_W-1:0]      cfg_data_i
);

  scg_pkg::deg_t                crc_degree_q, crc_degree_d;
  logic [scg_pkg::POLY_W-1:0]   poly_low_q, poly_low_d;
  logic                         accept;
  logic                         q_full;
  logic                         q_valid;
  logic                         q_rd;
  scg_pkg::entry_t              f_entry;
  logic [MAX_DEGREE-1:0]        f_rem;
  scg_pkg::entry_t              q_entry;
  logic [MAX_DEGREE-1:0]        q_rem;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_comb begin
    crc_degree_d = crc_degree_q;
    poly_low_d   = poly_low_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        scg_pkg::CFG_CRC_DEGREE: crc_degree_d = cfg_data_i[scg_pkg::DEG_W-1:0];
        scg_pkg::CFG_POLY_LOW:   poly_low_d   = cfg_data_i;
        default: begin
          crc_degree_d = crc_degree_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_degree_q <= scg_pkg::DEG_RESET;
      poly_low_q   <= scg_pkg::POLY_RESET;
    end else begin
      crc_degree_q <= crc_degree_d;
      poly_low_q   <= poly_low_d;
    end
  end

  scg_front #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .msg_bit_i    (msg_bit_i),
    .msg_last_i   (msg_last_i),
    .crc_degree_i (crc_degree_q),
    .poly_low_i   (poly_low_q),
    .entry_o      (f_entry),
    .rem_o        (f_rem)
  );

  scg_queue #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept),
    .wr_entry_i (f_entry),
    .wr_rem_i   (f_rem),
    .full_o     (q_full),
    .rd_en_i    (q_rd),
    .rd_entry_o (q_entry),
    .rd_rem_o   (q_rem),
    .valid_o    (q_valid)
  );

  scg_back #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_rem_i     (q_rem),
    .q_rd_o      (q_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .code_bit_o  (code_bit_o),
    .run_last_o  (run_last_o),
    .too_short_o (too_short_o)
  );

endmodule

// ===== rtl/scg_checker.sv =====
`timescale 1ns / 1ps
module scg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic code_bit_o,
  input logic run_last_o,
  input logic too_short_o
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("queue sides not idle during reset");

  a_short_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && too_short_o) |-> (run_last_o && !code_bit_o))
    else $error("too-short result not a final zero result");

  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> ##2 !empty)
    else $error("accepted request never reached the result side");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(code_bit_o) && $stable(run_last_o)
                          && $stable(too_short_o)))
    else $error("stalled result changed");

endmodule

bind serial_crc_codeword_generator scg_checker u_scg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .code_bit_o  (code_bit_o),
  .run_last_o  (run_last_o),
  .too_short_o (too_short_o)
);
